// File: hdl/srexu_pkg.sv
// Package for the stack/register execution unit: opcodes, operand kinds,
// print kinds and error codes. No dependencies.
package srexu_pkg;

	localparam logic [3:0] OP_JMP = 4'd0;
	localparam logic [3:0] OP_RET = 4'd1;
	localparam logic [3:0] OP_CALL = 4'd2;
	localparam logic [3:0] OP_PRINT = 4'd3;
	localparam logic [3:0] OP_PUSH = 4'd4;
	localparam logic [3:0] OP_POP = 4'd5;
	localparam logic [3:0] OP_ADD = 4'd6;
	localparam logic [3:0] OP_SUB = 4'd7;
	localparam logic [3:0] OP_MOV = 4'd8;
	localparam logic [3:0] OP_XOR = 4'd9;
	localparam logic [3:0] OP_MUL = 4'd10;
	localparam logic [3:0] OP_MOD = 4'd11;
	localparam logic [3:0] OP_BEQ = 4'd12;
	localparam logic [3:0] OP_BNE = 4'd13;
	localparam logic [3:0] OP_BGT = 4'd14;
	localparam logic [3:0] OP_BLT = 4'd15;

	// left operand kind codes
	localparam logic [1:0] LK_REG = 2'd0;
	localparam logic [1:0] LK_STK = 2'd1;
	// right operand kind codes
	localparam logic [1:0] RK_REG = 2'd1;
	localparam logic [1:0] RK_STK = 2'd2;

	// print kind codes
	localparam logic [1:0] PK_LIT = 2'd0;
	localparam logic [1:0] PK_REG = 2'd1;
	localparam logic [1:0] PK_STK = 2'd2;

	localparam logic [2:0] ERR_NONE = 3'd0;
	localparam logic [2:0] ERR_UNDERFLOW = 3'd1;
	localparam logic [2:0] ERR_RET = 3'd2;
	localparam logic [2:0] ERR_OVERFLOW = 3'd3;
	localparam logic [2:0] ERR_MODZERO = 3'd4;

	localparam int NUM_REGS = 26;

endpackage

// File: hdl/srexu_if.sv
// Valid/ready channel interface; payload type given as a parameter.
// Depends on nothing.
interface srexu_if #(
	parameter type payload_t = logic
) (
	input logic clk
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: hdl/stack_register_exec_unit.sv
// Top level of the stack/register execution unit.
// Depends on srexu_pkg and srexu_ram.
//
// channel | dir | handshake   | payload
// req     | in  | valid/ready | req_type pc dst_* src_* immediate target
// rsp     | out | valid/ready | redirect redirect_index print_* error
//
// After reset the stack RAM is swept once, with req.ready low. A ret passes
// through the states read top entry, check and raise; every other transaction
// through left read, right read, decide and raise, with a write-back before the
// raise where one is needed, and for mul or mod the 64 steps and a finishing step
// of the shared shift/add unit before the write-back.
// A new request is taken once the result register has been emptied.
// Stalls on rsp hold the result and keep req.ready low.
module stack_register_exec_unit
	import srexu_pkg::*;
#(
	parameter int STACK_DEPTH = 512,
	parameter int INDEX_BITS = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// request channel
	input  logic                  req_valid,
	output logic                  req_ready,
	input  logic [3:0]            req_type,
	input  logic [INDEX_BITS-1:0] pc,
	input  logic [1:0]            dst_kind,
	input  logic [4:0]            dst_reg,
	input  logic [3:0]            dst_offset,
	input  logic [1:0]            src_kind,
	input  logic [4:0]            src_reg,
	input  logic [3:0]            src_offset,
	input  logic [30:0]           immediate,
	input  logic [INDEX_BITS-1:0] target,
	// result channel
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output logic                  redirect,
	output logic [INDEX_BITS-1:0] redirect_index,
	output logic                  print_valid,
	output logic [1:0]            print_kind,
	output logic [4:0]            print_tag,
	output logic signed [63:0]    print_value,
	output logic [2:0]            error
);
	localparam int SPW = $clog2(STACK_DEPTH);

	// sequencer states
	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_RDL   = 4'd2;  // issue left slot read
	localparam logic [3:0] S_RDR   = 4'd3;  // latch left, issue right read
	localparam logic [3:0] S_EXEC  = 4'd4;  // latch right, decide
	localparam logic [3:0] S_ITER  = 4'd5;  // shared mul/mod unit
	localparam logic [3:0] S_WB    = 4'd6;
	localparam logic [3:0] S_OUT   = 4'd7;
	localparam logic [3:0] S_RETRD = 4'd8;

	logic [3:0] state_q;
	logic [SPW-1:0] sp_q, clr_q;

	// captured request
	logic [3:0]            op_q;
	logic [INDEX_BITS-1:0] pc_q, tgt_q;
	logic [1:0]            lk_q, rk_q;
	logic [4:0]            lreg_q, rreg_q;
	logic [3:0]            loff_q, roff_q;
	logic [30:0]           imm_q;

	logic [63:0] lv_q;
	logic [63:0] regs_q [NUM_REGS];

	// shared iterative unit: shift-add multiply / restoring remainder
	logic [63:0] acc_q, mcand_q, mplier_q;
	logic [6:0]  cnt_q;
	logic        neg_q;

	// stack RAM
	logic             ram_we;
	logic [SPW-1:0]   ram_waddr, ram_raddr;
	logic [31:0]      ram_wdata, ram_rdata;

	srexu_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// operand kind decode
	logic l_reg, l_stk, l_imm, r_reg, r_stk;
	assign l_reg = (lk_q == LK_REG);
	assign l_stk = (lk_q == LK_STK);
	assign l_imm = !l_reg && !l_stk;
	assign r_reg = (rk_q == RK_REG);
	assign r_stk = (rk_q == RK_STK);

	logic [SPW-1:0] laddr, raddr_c;
	assign laddr   = sp_q - SPW'(loff_q);
	assign raddr_c = sp_q - SPW'(roff_q);

	logic l_under, r_under;
	assign l_under = l_stk && ((SPW+4)'(loff_q) > (SPW+4)'(sp_q));
	assign r_under = r_stk && ((SPW+4)'(roff_q) > (SPW+4)'(sp_q));

	logic [63:0] lreg_val, rreg_val;
	assign lreg_val = (lreg_q < 5'(NUM_REGS)) ? regs_q[lreg_q] : 64'd0;
	assign rreg_val = (rreg_q < 5'(NUM_REGS)) ? regs_q[rreg_q] : 64'd0;

	logic sp_full;
	assign sp_full = (sp_q == SPW'(STACK_DEPTH - 1));

	// one step of the shared unit
	logic [64:0] rem_try;
	logic [63:0] rem_sh;
	assign rem_sh  = {acc_q[62:0], mcand_q[63]};
	assign rem_try = {1'b0, rem_sh} - {1'b0, mplier_q};

	// result register
	logic                  o_valid_q, o_redir_q, o_pv_q;
	logic [INDEX_BITS-1:0] o_ridx_q;
	logic [1:0]            o_pk_q;
	logic [4:0]            o_tag_q;
	logic [63:0]           o_val_q;
	logic [2:0]            o_err_q;
	logic [63:0]           res_q;

	assign req_ready      = (state_q == S_IDLE) && !o_valid_q;
	assign rsp_valid      = o_valid_q;
	assign redirect       = o_redir_q;
	assign redirect_index = o_ridx_q;
	assign print_valid    = o_pv_q;
	assign print_kind     = o_pk_q;
	assign print_tag      = o_tag_q;
	assign print_value    = o_val_q;
	assign error          = o_err_q;

	// stack RAM port control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = clr_q;
		ram_wdata = (clr_q == '0) ? 32'hFFFF_FFFF : 32'd0;
		ram_raddr = laddr;
		if (state_q == S_CLEAR) begin
			ram_we = 1'b1;
		end else if (state_q == S_RDR) begin
			ram_raddr = raddr_c;
		end else if (state_q == S_RDL && op_q == OP_RET) begin
			ram_raddr = sp_q;
		end else if (state_q == S_WB) begin
			ram_we = 1'b1;
			unique case (op_q)
				OP_CALL: begin
					ram_waddr = sp_q + 1'b1;
					ram_wdata = 32'(pc_q);
				end
				OP_PUSH: begin
					ram_waddr = sp_q + 1'b1;
					ram_wdata = lv_q[31:0];
				end
				default: begin
					ram_waddr = laddr;
					ram_wdata = res_q[31:0];
					ram_we    = l_stk;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_q     <= '0;
			sp_q      <= '0;
			o_valid_q <= 1'b0;
			for (int i = 0; i < NUM_REGS; i++) begin
				regs_q[i] <= 64'd0;
			end
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == SPW'(STACK_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					// the result is only ever pending here; drop it once taken
					if (o_valid_q && rsp_ready) begin
						o_valid_q <= 1'b0;
					end
					if (req_valid && req_ready) begin
						op_q   <= req_type;
						pc_q   <= pc;
						tgt_q  <= target;
						lk_q   <= dst_kind;
						rk_q   <= src_kind;
						lreg_q <= dst_reg;
						rreg_q <= src_reg;
						loff_q <= dst_offset;
						roff_q <= src_offset;
						imm_q  <= immediate;
						state_q <= S_RDL;
					end
				end
				S_RDL: begin
					// left read (or top entry for ret) issued this cycle
					state_q <= (op_q == OP_RET) ? S_RETRD : S_RDR;
				end
				S_RETRD: begin
					o_pv_q    <= 1'b0;
					o_pk_q    <= PK_LIT;
					o_tag_q   <= '0;
					o_val_q   <= '0;
					if (sp_q == '0 || ram_rdata == 32'hFFFF_FFFF) begin
						o_redir_q <= 1'b0;
						o_ridx_q  <= '0;
						o_err_q   <= ERR_RET;
					end else begin
						o_redir_q <= 1'b1;
						o_ridx_q  <= ram_rdata[INDEX_BITS-1:0];
						o_err_q   <= ERR_NONE;
						sp_q      <= sp_q - 1'b1;
					end
					state_q <= S_OUT;
				end
				S_RDR: begin
					lv_q <= l_reg ? lreg_val
						: l_stk ? {{32{ram_rdata[31]}}, ram_rdata}
						: {33'd0, imm_q};
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					logic [63:0] rv;
					logic [63:0] bl;
					logic        take;
					rv = r_reg ? rreg_val
						: r_stk ? {{32{ram_rdata[31]}}, ram_rdata}
						: {33'd0, imm_q};
					bl = lreg_val;
					o_redir_q <= 1'b0;
					o_ridx_q  <= '0;
					o_pv_q    <= 1'b0;
					o_pk_q    <= PK_LIT;
					o_tag_q   <= '0;
					o_val_q   <= '0;
					o_err_q   <= ERR_NONE;
					state_q   <= S_OUT;
					unique case (op_q)
						OP_JMP: begin
							o_redir_q <= 1'b1;
							o_ridx_q  <= tgt_q;
						end
						OP_RET: begin
							o_err_q <= ERR_RET;
						end
						OP_CALL: begin
							if (sp_full) begin
								o_err_q <= ERR_OVERFLOW;
							end else begin
								o_redir_q <= 1'b1;
								o_ridx_q  <= tgt_q;
								state_q   <= S_WB;
							end
						end
						OP_PRINT: begin
							if (l_under) begin
								o_err_q <= ERR_UNDERFLOW;
							end else begin
								o_pv_q  <= 1'b1;
								o_pk_q  <= l_reg ? PK_REG : l_stk ? PK_STK : PK_LIT;
								o_tag_q <= l_reg ? lreg_q : l_stk ? {1'b0, loff_q} : 5'd0;
								o_val_q <= lv_q;
							end
						end
						OP_PUSH: begin
							if (l_under) begin
								o_err_q <= ERR_UNDERFLOW;
							end else if (sp_full) begin
								o_err_q <= ERR_OVERFLOW;
							end else begin
								state_q <= S_WB;
							end
						end
						OP_POP: begin
							if (32'(imm_q) > 32'(sp_q)) begin
								o_err_q <= ERR_UNDERFLOW;
							end else begin
								sp_q <= sp_q - SPW'(imm_q);
							end
						end
						OP_BEQ, OP_BNE, OP_BGT, OP_BLT: begin
							if (r_under) begin
								o_err_q <= ERR_UNDERFLOW;
							end else begin
								unique case (op_q)
									OP_BEQ: take = (bl == rv);
									OP_BNE: take = (bl != rv);
									OP_BGT: take = ($signed(bl) > $signed(rv));
									default: take = ($signed(bl) < $signed(rv));
								endcase
								o_redir_q <= take;
								o_ridx_q  <= take ? tgt_q : '0;
							end
						end
						default: begin
							// binary operations
							if (l_under || r_under) begin
								o_err_q <= ERR_UNDERFLOW;
							end else if (!l_imm) begin
								unique case (op_q)
									OP_ADD: begin
										res_q   <= lv_q + rv;
										state_q <= S_WB;
									end
									OP_SUB: begin
										res_q   <= lv_q - rv;
										state_q <= S_WB;
									end
									OP_MOV: begin
										res_q   <= rv;
										state_q <= S_WB;
									end
									OP_XOR: begin
										res_q   <= lv_q ^ rv;
										state_q <= S_WB;
									end
									OP_MUL: begin
										acc_q    <= '0;
										mcand_q  <= lv_q;
										mplier_q <= rv;
										cnt_q    <= 7'd64;
										state_q  <= S_ITER;
									end
									default: begin
										if (rv == 64'd0) begin
											o_err_q <= ERR_MODZERO;
										end else begin
											// magnitudes for remainder
											acc_q    <= '0;
											mcand_q  <= lv_q[63] ? -lv_q : lv_q;
											mplier_q <= rv[63] ? -rv : rv;
											neg_q    <= lv_q[63];
											cnt_q    <= 7'd64;
											state_q  <= S_ITER;
										end
									end
								endcase
							end
						end
					endcase
				end
				S_ITER: begin
					if (cnt_q == 7'd0) begin
						if (op_q == OP_MUL) begin
							res_q <= acc_q;
						end else begin
							res_q <= neg_q ? -acc_q : acc_q;
						end
						state_q <= S_WB;
					end else begin
						cnt_q <= cnt_q - 1'b1;
						if (op_q == OP_MUL) begin
							// add shifted multiplicand for each set multiplier bit
							if (mplier_q[0]) begin
								acc_q <= acc_q + mcand_q;
							end
							mcand_q  <= {mcand_q[62:0], 1'b0};
							mplier_q <= {1'b0, mplier_q[63:1]};
						end else begin
							// restoring remainder, one dividend bit per cycle
							mcand_q <= {mcand_q[62:0], 1'b0};
							if (acc_q[63] || !rem_try[64]) begin
								acc_q <= rem_try[63:0];
							end else begin
								acc_q <= rem_sh;
							end
						end
					end
				end
				S_WB: begin
					if (op_q == OP_CALL || op_q == OP_PUSH) begin
						sp_q <= sp_q + 1'b1;
					end else if (l_reg && lreg_q < 5'(NUM_REGS)) begin
						regs_q[lreg_q] <= res_q;
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					// raise the result once, then wait in idle for it to drain
					o_valid_q <= 1'b1;
					state_q   <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// no request taken while a result is pending
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !req_ready)
		else $error("request accepted with result pending");

	// stack pointer never reaches the last slot plus one
	assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SPW'(STACK_DEPTH - 1))
		else $error("stack pointer out of range");

	// an error result carries no other event
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && error != ERR_NONE) |-> (!redirect && !print_valid))
		else $error("error result with side event");

	// stack pointer moves only when a transaction is in flight
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |=> (sp_q == $past(sp_q)))
		else $error("stack pointer moved while idle");

endmodule

// File: hdl/srexu_ram.sv
// Generic simple dual-port RAM (one write port, one read port) with registered read.
// Depends on nothing.
module srexu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: tb/stack_register_exec_unit_test.sv
// Self-checking testbench for stack_register_exec_unit: random and directed
// instructions on valid/ready channels, checked against an in-bench predictor.
// Depends on srexu_pkg, srexu_if and the unit under test.
module stack_register_exec_unit_test;
	import srexu_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = 512;
	localparam int IDX_W = 12;

	typedef struct packed {
		logic [3:0]       req_type;
		logic [IDX_W-1:0] pc;
		logic [1:0]       dst_kind;
		logic [4:0]       dst_reg;
		logic [3:0]       dst_offset;
		logic [1:0]       src_kind;
		logic [4:0]       src_reg;
		logic [3:0]       src_offset;
		logic [30:0]      immediate;
		logic [IDX_W-1:0] target;
	} instr_t;

	typedef struct packed {
		logic             redirect;
		logic [IDX_W-1:0] redirect_index;
		logic             print_valid;
		logic [1:0]       print_kind;
		logic [4:0]       print_tag;
		logic [63:0]      print_value;
		logic [2:0]       error;
	} outcome_t;

	// Executes accepted instructions on a private copy of the machine state and
	// holds the outcomes still owed by the unit, oldest first.
	class exec_scoreboard;
		logic [63:0] regs [NUM_REGS];
		logic [31:0] stk [DEPTH];
		int unsigned sp;
		outcome_t owed [$];
		int mismatches;

		function new();
			foreach (regs[i]) regs[i] = '0;
			foreach (stk[i]) stk[i] = '0;
			stk[0] = 32'hFFFF_FFFF;
			sp = 0;
			mismatches = 0;
		endfunction

		function automatic logic [63:0] reg_rd(logic [4:0] idx);
			return (idx < NUM_REGS) ? regs[idx] : 64'd0;
		endfunction

		function automatic logic [63:0] slot_rd(logic [3:0] off);
			return {{32{stk[sp - off][31]}}, stk[sp - off]};
		endfunction

		// truncated remainder, sign of the dividend
		function automatic logic [63:0] rem64(logic [63:0] a, logic [63:0] b);
			logic [63:0] ua, ub, r;
			ua = a[63] ? -a : a;
			ub = b[63] ? -b : b;
			r = ua % ub;
			return a[63] ? -r : r;
		endfunction

		function automatic void note_instr(instr_t t);
			outcome_t o;
			logic [2:0] err;
			logic l_reg, l_stk, r_reg, r_stk;
			logic [63:0] lv, rv, res;
			o = '0;
			err = ERR_NONE;
			l_reg = (t.dst_kind == LK_REG);
			l_stk = (t.dst_kind == LK_STK);
			r_reg = (t.src_kind == RK_REG);
			r_stk = (t.src_kind == RK_STK);
			lv = l_reg ? reg_rd(t.dst_reg) : 64'(t.immediate);
			rv = r_reg ? reg_rd(t.src_reg) : 64'(t.immediate);
			case (t.req_type)
				OP_JMP: begin
					o.redirect = 1'b1;
					o.redirect_index = t.target;
				end
				OP_RET: begin
					if (sp == 0 || stk[sp] == 32'hFFFF_FFFF) begin
						err = ERR_RET;
					end else begin
						o.redirect = 1'b1;
						o.redirect_index = stk[sp][IDX_W-1:0];
						sp--;
					end
				end
				OP_CALL: begin
					if (sp >= DEPTH - 1) begin
						err = ERR_OVERFLOW;
					end else begin
						sp++;
						stk[sp] = 32'(t.pc);
						o.redirect = 1'b1;
						o.redirect_index = t.target;
					end
				end
				OP_PRINT, OP_PUSH: begin
					if (l_stk && t.dst_offset > sp) begin
						err = ERR_UNDERFLOW;
					end else begin
						if (l_stk) lv = slot_rd(t.dst_offset);
						if (t.req_type == OP_PRINT) begin
							o.print_valid = 1'b1;
							o.print_kind = l_reg ? PK_REG : (l_stk ? PK_STK : PK_LIT);
							o.print_tag = l_reg ? t.dst_reg : (l_stk ? 5'(t.dst_offset) : 5'd0);
							o.print_value = lv;
						end else if (sp >= DEPTH - 1) begin
							err = ERR_OVERFLOW;
						end else begin
							sp++;
							stk[sp] = lv[31:0];
						end
					end
				end
				OP_POP: begin
					if (t.immediate > sp) err = ERR_UNDERFLOW;
					else sp -= t.immediate;
				end
				OP_BEQ, OP_BNE, OP_BGT, OP_BLT: begin
					if (r_stk && t.src_offset > sp) begin
						err = ERR_UNDERFLOW;
					end else begin
						logic take;
						logic signed [63:0] a, b;
						if (r_stk) rv = slot_rd(t.src_offset);
						a = reg_rd(t.dst_reg);
						b = rv;
						case (t.req_type)
							OP_BEQ: take = (a == b);
							OP_BNE: take = (a != b);
							OP_BGT: take = (a > b);
							default: take = (a < b);
						endcase
						if (take) begin
							o.redirect = 1'b1;
							o.redirect_index = t.target;
						end
					end
				end
				default: begin
					// arithmetic: add sub mov xor mul mod
					if ((l_stk && t.dst_offset > sp) || (r_stk && t.src_offset > sp)) begin
						err = ERR_UNDERFLOW;
					end else if (l_reg || l_stk) begin
						if (l_stk) lv = slot_rd(t.dst_offset);
						if (r_stk) rv = slot_rd(t.src_offset);
						case (t.req_type)
							OP_ADD: res = lv + rv;
							OP_SUB: res = lv - rv;
							OP_MOV: res = rv;
							OP_XOR: res = lv ^ rv;
							OP_MUL: res = lv * rv;
							default: begin
								if (rv == 0) err = ERR_MODZERO;
								else res = rem64(lv, rv);
							end
						endcase
						if (err == ERR_NONE) begin
							if (l_reg) begin
								if (t.dst_reg < NUM_REGS) regs[t.dst_reg] = res;
							end else begin
								stk[sp - t.dst_offset] = res[31:0];
							end
						end
					end
				end
			endcase
			if (err != ERR_NONE) begin
				o = '0;
				o.error = err;
			end
			owed.push_back(o);
		endfunction

		function automatic void check_outcome(outcome_t got);
			outcome_t want;
			if (owed.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", got);
				return;
			end
			want = owed.pop_front();
			if (got.redirect !== want.redirect || got.redirect_index !== want.redirect_index
				|| got.print_valid !== want.print_valid || got.print_kind !== want.print_kind
				|| got.print_tag !== want.print_tag || got.print_value !== want.print_value
				|| got.error !== want.error) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"mismatch: expected redir=%0b idx=%0d pv=%0b pk=%0d tag=%0d",
						" val=%0d err=%0d, got redir=%0b idx=%0d pv=%0b pk=%0d tag=%0d",
						" val=%0d err=%0d"},
						want.redirect, want.redirect_index, want.print_valid, want.print_kind,
						want.print_tag, $signed(want.print_value), want.error,
						got.redirect, got.redirect_index, got.print_valid, got.print_kind,
						got.print_tag, $signed(got.print_value), got.error);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic calm = 1'b0;   // when set, neither side idles

	srexu_if #(.payload_t(instr_t)) instr_ch (clk);
	srexu_if #(.payload_t(outcome_t)) outcome_ch (clk);

	wire              rsp_valid_w, redirect_w, print_valid_w;
	wire [IDX_W-1:0]  redirect_index_w;
	wire [1:0]        print_kind_w;
	wire [4:0]        print_tag_w;
	wire [63:0]       print_value_w;
	wire [2:0]        error_w;

	exec_scoreboard sb = new();

	// clock: 12 ns period
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	stack_register_exec_unit #(.STACK_DEPTH(DEPTH), .INDEX_BITS(IDX_W)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(instr_ch.valid),
		.req_ready(instr_ch.ready),
		.req_type(instr_ch.data.req_type),
		.pc(instr_ch.data.pc),
		.dst_kind(instr_ch.data.dst_kind),
		.dst_reg(instr_ch.data.dst_reg),
		.dst_offset(instr_ch.data.dst_offset),
		.src_kind(instr_ch.data.src_kind),
		.src_reg(instr_ch.data.src_reg),
		.src_offset(instr_ch.data.src_offset),
		.immediate(instr_ch.data.immediate),
		.target(instr_ch.data.target),
		.rsp_valid(rsp_valid_w),
		.rsp_ready(outcome_ch.ready),
		.redirect(redirect_w),
		.redirect_index(redirect_index_w),
		.print_valid(print_valid_w),
		.print_kind(print_kind_w),
		.print_tag(print_tag_w),
		.print_value(print_value_w),
		.error(error_w)
	);

	// Gather the flat result ports into the result channel.
	assign outcome_ch.valid = rsp_valid_w;
	assign outcome_ch.data = {redirect_w, redirect_index_w, print_valid_w, print_kind_w,
		print_tag_w, print_value_w, error_w};

	// Result side: hold ready low for a randomly drawn stall after each accepted result, check on acceptance.
	initial begin : result_sink
		int stall;
		logic rdy;
		stall = 0;
		outcome_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (outcome_ch.valid && outcome_ch.ready) begin
				sb.check_outcome(outcome_ch.data);
				stall = calm ? 0 : $urandom_range(0, 3);
			end else if (stall > 0) begin
				stall--;
			end
			rdy = arst_n && (stall == 0);
			outcome_ch.ready <= rdy;
		end
	end

	// Drive one instruction and hold it until accepted. Valid stays high into the
	// next instruction when no gap is drawn, so it is never dropped and raised
	// within one step.
	task automatic send_instr(instr_t t);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			instr_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		instr_ch.valid <= 1'b1;
		instr_ch.data <= t;
		do @(posedge clk); while (!instr_ch.ready);
		sb.note_instr(t);
	endtask

	// Hold until every expected result has come back.
	task automatic drain();
		while (sb.owed.size() != 0) @(posedge clk);
	endtask

	function automatic instr_t mk(logic [3:0] op, logic [1:0] dk, logic [4:0] dr,
		logic [3:0] doff, logic [1:0] sk, logic [4:0] sr, logic [3:0] soff,
		logic [30:0] imm);
		instr_t t;
		t.req_type = op;
		t.pc = IDX_W'($urandom);
		t.dst_kind = dk;
		t.dst_reg = dr;
		t.dst_offset = doff;
		t.src_kind = sk;
		t.src_reg = sr;
		t.src_offset = soff;
		t.immediate = imm;
		t.target = IDX_W'($urandom);
		return t;
	endfunction

	function automatic logic [30:0] rand_imm();
		case ($urandom_range(0, 5))
			0: return 31'd0;
			1: return 31'h7FFF_FFFF;
			2: return 31'($urandom_range(0, 9));
			default: return 31'($urandom);
		endcase
	endfunction

	// Random instruction, biased toward offsets that land inside the stack.
	function automatic instr_t rand_instr();
		instr_t t;
		logic [3:0] op;
		int r;
		r = $urandom_range(0, 99);
		if (r < 18) op = OP_PUSH;
		else if (r < 26) op = OP_POP;
		else if (r < 31) op = OP_CALL;
		else if (r < 37) op = OP_RET;
		else if (r < 45) op = OP_PRINT;
		else if (r < 47) op = OP_JMP;
		else if (r < 57) op = 4'($urandom_range(OP_BEQ, OP_BLT));
		else op = 4'($urandom_range(OP_ADD, OP_MOD));
		t = mk(op, ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2)),
			($urandom_range(0, 9) == 0) ? 5'($urandom_range(26, 31)) : 5'($urandom_range(0, 25)),
			($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(0, 9)),
			($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2)),
			($urandom_range(0, 9) == 0) ? 5'($urandom_range(26, 31)) : 5'($urandom_range(0, 25)),
			($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(0, 9)),
			rand_imm());
		// keep pop counts mostly small so the stack stays populated
		if (op == OP_POP && $urandom_range(0, 7) != 0) t.immediate = 31'($urandom_range(0, 3));
		return t;
	endfunction

	initial begin : stimulus
		instr_ch.valid = 1'b0;
		instr_ch.data = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty-stack errors, each operand kind, extremes, special cases.
		send_instr(mk(OP_RET, 0, 0, 0, 0, 0, 0, 0));             // ret without call
		send_instr(mk(OP_POP, 0, 0, 0, 0, 0, 0, 1));             // pop below bottom
		send_instr(mk(OP_PRINT, LK_STK, 0, 1, 0, 0, 0, 0));      // slot below bottom
		send_instr(mk(OP_PRINT, LK_STK, 0, 0, 0, 0, 0, 0));      // bottom mark
		send_instr(mk(OP_PRINT, 2'd2, 0, 0, 0, 0, 0, 31'h7FFF_FFFF));
		send_instr(mk(OP_MOV, LK_REG, 0, 0, 2'd0, 0, 0, 31'h7FFF_FFFF));
		send_instr(mk(OP_MUL, LK_REG, 0, 0, RK_REG, 0, 0, 0));   // square it
		send_instr(mk(OP_MUL, LK_REG, 0, 0, RK_REG, 0, 0, 0));
		send_instr(mk(OP_PRINT, LK_REG, 0, 0, 0, 0, 0, 0));
		send_instr(mk(OP_MOD, LK_REG, 1, 0, 2'd0, 0, 0, 0));     // modulo by zero
		send_instr(mk(OP_SUB, LK_REG, 1, 0, 2'd0, 0, 0, 31'd7)); // r1 = -7
		send_instr(mk(OP_MOD, LK_REG, 1, 0, 2'd0, 0, 0, 31'd3)); // negative dividend
		send_instr(mk(OP_PUSH, LK_REG, 1, 0, 0, 0, 0, 0));
		send_instr(mk(OP_CALL, 0, 0, 0, 0, 0, 0, 0));
		send_instr(mk(OP_RET, 0, 0, 0, 0, 0, 0, 0));
		send_instr(mk(OP_XOR, LK_STK, 0, 0, RK_STK, 0, 0, 0));
		send_instr(mk(OP_ADD, 2'd2, 0, 0, RK_STK, 0, 9, 0));     // imm dest, slot underflow
		send_instr(mk(OP_ADD, 2'd3, 0, 0, RK_REG, 0, 0, 0));     // imm dest, no effect
		send_instr(mk(OP_MOV, LK_REG, 5'd31, 0, RK_REG, 0, 0, 0)); // write to absent reg
		send_instr(mk(OP_PRINT, LK_REG, 5'd31, 0, 0, 0, 0, 0));
		send_instr(mk(OP_BEQ, LK_STK, 1, 0, 2'd3, 0, 0, 31'd0)); // left kind ignored
		send_instr(mk(OP_BNE, 0, 0, 0, RK_STK, 0, 15, 0));
		send_instr(mk(OP_BGT, 0, 0, 0, RK_REG, 1, 0, 0));
		send_instr(mk(OP_BLT, 0, 1, 0, 2'd0, 0, 0, 31'd0));
		send_instr(mk(OP_JMP, 0, 0, 0, 0, 0, 0, 0));

		// Hold the sender until the unit has drained.
		drain();

		for (int i = 0; i < 1500; i++) begin
			if (i % 200 == 0) calm = ($urandom_range(0, 3) == 0);
			if (i == 900) begin
				// fill the stack to the top, then hit overflow on push and call
				while (sb.sp < DEPTH - 1)
					send_instr(mk(OP_PUSH, 2'd2, 0, 0, 0, 0, 0, 31'($urandom)));
				send_instr(mk(OP_PUSH, LK_REG, 2, 0, 0, 0, 0, 0));
				send_instr(mk(OP_CALL, 0, 0, 0, 0, 0, 0, 0));
				send_instr(mk(OP_XOR, LK_STK, 0, 9, RK_STK, 0, 3, 0));
				send_instr(mk(OP_POP, 0, 0, 0, 0, 0, 0, 31'(sb.sp - 2)));
			end
			send_instr(rand_instr());
		end
		instr_ch.valid <= 1'b0;

		drain();
		repeat (200) @(posedge clk);
		if (sb.mismatches == 0 && sb.owed.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#30_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

// File: stack_register_exec_unit.f
hdl/srexu_pkg.sv
hdl/srexu_if.sv
hdl/srexu_ram.sv
hdl/stack_register_exec_unit.sv
tb/stack_register_exec_unit_test.sv
